// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define CHK_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define CHK_ALWAYS(label, clk, rst_n, prop)
`define CHK_IMPLY(label, clk, rst_n, pre, post)
`endif
`endif

// ===== design/sstf_pkg.sv =====
// ---------------------------------------------------------------------------
// sstf_pkg
// Shared types and constants of the shortest-seek batch scheduler.
// ---------------------------------------------------------------------------
package sstf_pkg;
  localparam int QUEUE_SLOTS = 64;
  localparam int SECTOR_BITS = 48;
  localparam int TAG_BITS    = 8;
  localparam int IDX_W       = $clog2(QUEUE_SLOTS);
  localparam int CNT_W       = $clog2(QUEUE_SLOTS + 1);
  localparam int FD_W        = 7;
  localparam int WAIT_W      = 13;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_TICK  = 2'd1,
    FN_DRAIN = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLUSH_DEPTH = 2'd0,
    CFG_MAX_WAIT    = 2'd1,
    CFG_RSVD2       = 2'd2,
    CFG_RSVD3       = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic [1:0]             func;
    logic [SECTOR_BITS-1:0] sector;
    logic [TAG_BITS-1:0]    tag;
  } in_word_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]    out_tag;
    logic [SECTOR_BITS-1:0] out_sector;
    logic                   toward_higher;
    logic                   last;
  } out_word_t;

  typedef struct packed {
    logic                   valid;
    logic [SECTOR_BITS-1:0] sector;
    logic [TAG_BITS-1:0]    tag;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic clear;
  } cell_ctl_t;
endpackage

// ===== design/sstf_cell.sv =====
// ---------------------------------------------------------------------------
// sstf_cell
// One queue slot of the rotating ring; passes its entry to its neighbor.
// ---------------------------------------------------------------------------
module sstf_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  sstf_pkg::cell_ctl_t ctl,
  input  sstf_pkg::slot_t   shift_in,
  input  sstf_pkg::slot_t   load_in,
  output sstf_pkg::slot_t   slot_out
);
  import sstf_pkg::*;

  logic                   valid_r;
  logic [SECTOR_BITS-1:0] sector_r;
  logic [TAG_BITS-1:0]    tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= shift_in.valid;
    end else if (ctl.load) begin
      valid_r <= 1'b1;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      sector_r <= shift_in.sector;
      tag_r    <= shift_in.tag;
    end else if (ctl.load) begin
      sector_r <= load_in.sector;
      tag_r    <= load_in.tag;
    end
  end

  assign slot_out = '{valid: valid_r, sector: sector_r, tag: tag_r};
endmodule

// ===== design/sstf_pick.sv =====
// ---------------------------------------------------------------------------
// sstf_pick
// Tracks the nearest valid entry as the ring streams past the head cell.
// ---------------------------------------------------------------------------
module sstf_pick (
  input  logic                             clk,
  input  logic                             step,
  input  logic                             first,
  input  logic [sstf_pkg::IDX_W-1:0]       step_idx,
  input  sstf_pkg::slot_t                  cand,
  input  logic [sstf_pkg::SECTOR_BITS-1:0] head,
  output logic                             found,
  output logic [sstf_pkg::IDX_W-1:0]       best_idx,
  output logic [sstf_pkg::SECTOR_BITS-1:0] best_sector,
  output logic [sstf_pkg::TAG_BITS-1:0]    best_tag
);
  import sstf_pkg::*;

  logic                   found_r;
  logic [IDX_W-1:0]       idx_r;
  logic [SECTOR_BITS-1:0] dist_r;
  logic [SECTOR_BITS-1:0] sector_r;
  logic [TAG_BITS-1:0]    tag_r;
  logic [SECTOR_BITS-1:0] seek;
  logic                   take;
  logic                   have;

  always_comb begin
    seek = (cand.sector > head) ? cand.sector - head : head - cand.sector;
    have = found_r && !first;
    take = cand.valid && (!have || (seek < dist_r));
  end

  // Strict compare in ascending slot order keeps the oldest on a tie.
  always_ff @(posedge clk) begin
    if (step) begin
      found_r <= have || cand.valid;
      if (take) begin
        idx_r    <= step_idx;
        dist_r   <= seek;
        sector_r <= cand.sector;
        tag_r    <= cand.tag;
      end
    end
  end

  assign found       = found_r;
  assign best_idx    = idx_r;
  assign best_sector = sector_r;
  assign best_tag    = tag_r;
endmodule

// ===== design/sstf_batch_request_scheduler.sv =====
// ---------------------------------------------------------------------------
// sstf_batch_request_scheduler
// Batching shortest-seek-first request scheduler built on a ring of slots.
// ---------------------------------------------------------------------------
// Usage: input words carry func (add, tick, drain), sector and tag. An add
// stores the request in the next free slot and restarts the wait timer.
// A flush starts when the pending count reaches flush_depth (or the queue is
// full), when the timer reaches max_wait_ticks on tick words, or on a drain, if the queue holds a request.
// During a flush in_stall stays high and the block sends one output word per
// pending request: the request nearest the head, oldest first on a tie.
// Each dispatch rotates the whole ring of QUEUE_SLOTS cells once past the
// compare unit; an output stall can hold a flush. Words that cause no
// output leave in_stall low.
// The output word sits in a register; while out_stall is high the block
// holds it and waits before committing the next dispatch.
// Reset is synchronous: the queue empties, the head returns to sector one,
// the timer disarms and the registers return to 50 and 5000.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sstf_batch_request_scheduler (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sstf_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sstf_pkg::out_word_t              out_data,
  input  logic                             cfg_we,
  input  logic [sstf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sstf_pkg::CFG_W-1:0]       cfg_wdata
);
  import sstf_pkg::*;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       pending_r, pending_nxt;
  logic [SECTOR_BITS-1:0] head_r;
  logic [WAIT_W-1:0]      wait_r, wait_nxt;
  logic                   armed_r, armed_nxt;
  logic [IDX_W-1:0]       step_r;
  logic [FD_W-1:0]        flush_depth_r;
  logic [WAIT_W-1:0]      max_wait_r;
  logic                   out_valid_r;
  out_word_t              out_r;

  logic                   in_acc, add_acc, tick_acc, drain_acc;
  logic [CNT_W-1:0]       cnt_add;
  logic [WAIT_W-1:0]      wait_inc;
  logic                   flush_go, put_go;

  slot_t                  ring [QUEUE_SLOTS];
  slot_t                  load_word;
  logic                   found;
  logic [IDX_W-1:0]       best_idx;
  logic [SECTOR_BITS-1:0] best_sector;
  logic [TAG_BITS-1:0]    best_tag;

  // Decode of the accepted input word.
  always_comb begin
    in_acc    = in_valid && !in_stall;
    add_acc   = in_acc && (in_data.func == FN_ADD) &&
                (pending_r < CNT_W'(QUEUE_SLOTS));
    tick_acc  = in_acc && (in_data.func == FN_TICK) && armed_r;
    drain_acc = in_acc && (in_data.func == FN_DRAIN);
    cnt_add   = pending_r + CNT_W'(1);
    wait_inc  = (wait_r != {WAIT_W{1'b1}}) ? wait_r + WAIT_W'(1) : wait_r;
    flush_go  = drain_acc ||
                (tick_acc && (wait_inc >= max_wait_r)) ||
                (add_acc && (({{FD_W{1'b0}}, cnt_add} >= {{CNT_W{1'b0}}, flush_depth_r}) ||
                             (cnt_add >= CNT_W'(QUEUE_SLOTS))));
    put_go    = (state_r == ST_PUT) && (!out_valid_r || !out_stall);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (flush_go && ((add_acc ? cnt_add : pending_r) != '0)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (step_r == IDX_W'(QUEUE_SLOTS - 1)) state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (put_go) state_nxt = (pending_r == CNT_W'(1)) ? ST_IDLE : ST_SCAN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    in_stall = (state_r != ST_IDLE);
  end

  // Queue count and timer.
  always_comb begin
    pending_nxt = pending_r;
    wait_nxt    = wait_r;
    armed_nxt   = armed_r;
    if (add_acc) begin
      pending_nxt = cnt_add;
      wait_nxt    = '0;
      armed_nxt   = 1'b1;
    end else if (tick_acc) begin
      wait_nxt = wait_inc;
    end
    if (flush_go) begin
      wait_nxt  = '0;
      armed_nxt = 1'b0;
    end
    if (put_go) pending_nxt = pending_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pending_r     <= '0;
      wait_r        <= '0;
      armed_r       <= 1'b0;
      step_r        <= '0;
      head_r        <= SECTOR_BITS'(1);
      flush_depth_r <= FD_W'(50);
      max_wait_r    <= WAIT_W'(5000);
      out_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pending_r <= pending_nxt;
      wait_r    <= wait_nxt;
      armed_r   <= armed_nxt;
      step_r    <= (state_r == ST_SCAN) ? step_r + IDX_W'(1) : '0;
      if (cfg_we && (cfg_index == CFG_FLUSH_DEPTH)) flush_depth_r <= cfg_wdata[FD_W-1:0];
      if (cfg_we && (cfg_index == CFG_MAX_WAIT))    max_wait_r    <= cfg_wdata[WAIT_W-1:0];
      if (put_go) begin
        head_r      <= best_sector;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put_go) begin
      out_r.out_tag       <= best_tag;
      out_r.out_sector    <= best_sector;
      out_r.toward_higher <= (best_sector >= head_r);
      out_r.last          <= (pending_r == CNT_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Ring of slots: each cell takes its upper neighbor's entry while scanning,
  // so cell zero shows slot k at scan step k and the ring is home after a pass.
  assign load_word = '{valid: 1'b1, sector: in_data.sector, tag: in_data.tag};

  for (genvar i = 0; i < QUEUE_SLOTS; i++) begin : g_cell
    cell_ctl_t ctl;
    always_comb begin
      ctl.shift = (state_r == ST_SCAN);
      ctl.load  = add_acc && (pending_r[IDX_W-1:0] == IDX_W'(i));
      ctl.clear = put_go && (best_idx == IDX_W'(i));
    end
    sstf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .shift_in (ring[(i + 1) % QUEUE_SLOTS]),
      .load_in  (load_word),
      .slot_out (ring[i])
    );
  end

  sstf_pick u_pick (
    .clk         (clk),
    .step        (state_r == ST_SCAN),
    .first       (step_r == '0),
    .step_idx    (step_r),
    .cand        (ring[0]),
    .head        (head_r),
    .found       (found),
    .best_idx    (best_idx),
    .best_sector (best_sector),
    .best_tag    (best_tag)
  );

  // A dispatch always finds a request, the count never passes the slot
  // count, an armed timer implies a nonempty queue, and each dispatch lowers the count by one.
  `CHK_ALWAYS(a_put_found, clk, rst_n, !(state_r == ST_PUT) || found)
  `CHK_ALWAYS(a_pending_max, clk, rst_n, pending_r <= CNT_W'(QUEUE_SLOTS))
  `CHK_ALWAYS(a_armed_nonempty, clk, rst_n, !armed_r || (pending_r != '0))
  `CHK_IMPLY(a_put_counts, clk, rst_n, put_go, pending_r == $past(pending_r) - CNT_W'(1))
endmodule
